[design/htd_pkg.sv]
// ----------------------------------------------------------------------------
// htd_pkg
// Shared types and constants of the Huffman tree decoder unit.
// ----------------------------------------------------------------------------
package htd_pkg;

	// walk restarts here after every decoded symbol
	localparam logic [7:0] ROOT_NODE = 8'd254;
	localparam logic [2:0] LAST_BIT  = 3'd7;

	// slave tdata: first_byte, data_byte, node_index, left_value, left_is_node,
	// right_value, right_is_node, then zero padding
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 8;
	localparam int CFG_W     = 24;

	typedef struct packed {
		logic       r_is_node;
		logic [7:0] r_val;
		logic       l_is_node;
		logic [7:0] l_val;
	} node_t;

	typedef struct packed {
		logic       is_load;
		logic       first;
		logic [7:0] data;
		logic [7:0] idx;
		node_t      node;
	} item_t;

	// one step of the walk as seen by the output stage
	typedef struct packed {
		logic       push;
		logic       finish;
		logic [7:0] sym;
		logic       done;
	} sym_t;

	typedef enum logic [1:0] {
		WS_IDLE,
		WS_PREP,
		WS_BITS
	} walk_state_t;

endpackage

[design/htd_front.sv]
// ----------------------------------------------------------------------------
// htd_front
// Input side: takes stream transactions, unpacks them into items and holds
// them in a two-entry queue for the walk engine.
// ----------------------------------------------------------------------------
module htd_front import htd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic [0:0]           s_tuser,
	output logic                 q_valid,
	output item_t                q_item,
	input  logic                 q_pop
);

	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	item_t              in_item;
	item_t              slots_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               push;
	logic               pop;

	always_comb begin
		in_item                = '0;
		in_item.is_load        = s_tuser[0];
		in_item.first          = s_tdata[0];
		in_item.data           = s_tdata[8:1];
		in_item.idx            = s_tdata[16:9];
		in_item.node.l_val     = s_tdata[24:17];
		in_item.node.l_is_node = s_tdata[25];
		in_item.node.r_val     = s_tdata[33:26];
		in_item.node.r_is_node = s_tdata[34];
	end

	assign s_tready = (cnt_q != CNT_W'(DEPTH));
	assign q_valid  = (cnt_q != '0);
	assign q_item   = slots_q[rd_ptr_q];
	assign push     = s_tvalid && s_tready;
	assign pop      = q_pop && q_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[design/htd_walk.sv]
// ----------------------------------------------------------------------------
// htd_walk
// Back end: node store, tree walk one bit per cycle while the output stage
// takes symbols, length register and produced-symbol count.
// ----------------------------------------------------------------------------
module htd_walk import htd_pkg::*; #(
	parameter int NODE_COUNT  = 256,
	parameter int LENGTH_BITS = 24
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [CFG_W-1:0] cfg_wr_data,
	input  logic             q_valid,
	input  item_t            q_item,
	output logic             q_pop,
	input  logic             pend_ready,
	output sym_t             sym
);

	localparam int         ADDR_W     = $clog2(NODE_COUNT);
	localparam logic [8:0] NODE_LIMIT = 9'(NODE_COUNT);

	node_t                  mem [NODE_COUNT];

	walk_state_t            state_q;
	walk_state_t            state_d;
	logic [7:0]             cur_node_q;
	logic [LENGTH_BITS-1:0] count_q;
	logic [LENGTH_BITS-1:0] count_inc;
	logic [LENGTH_BITS-1:0] len_q;
	logic [2:0]             bit_idx_q;
	logic [7:0]             data_q;
	node_t                  rd_node_q;
	logic                   rd_hit_q;
	logic                   rd_ok_q;

	logic                   path;
	logic [7:0]             child_val;
	logic                   child_is_node;
	logic                   stop;
	logic                   produce;
	logic                   step;
	logic                   finish;
	logic [7:0]             nxt_node;
	logic [7:0]             rd_addr;
	logic                   mem_we;
	logic                   start_data;

	// child picked by the current bit; out-of-range nodes read as all zero
	assign path          = data_q[bit_idx_q];
	assign child_val     = !rd_hit_q ? 8'd0 : (path ? rd_node_q.r_val : rd_node_q.l_val);
	assign child_is_node = rd_hit_q && (path ? rd_node_q.r_is_node : rd_node_q.l_is_node);
	assign stop          = (count_q >= len_q);
	assign produce       = !stop && !child_is_node;
	assign count_inc     = count_q + 1'b1;
	assign nxt_node      = stop ? cur_node_q : (child_is_node ? child_val : ROOT_NODE);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			WS_IDLE: begin
				if (q_valid && !q_item.is_load) begin
					state_d = (q_item.first || !rd_ok_q) ? WS_PREP : WS_BITS;
				end
			end
			WS_PREP: state_d = WS_BITS;
			WS_BITS: begin
				if (step && finish) begin
					state_d = WS_IDLE;
				end
			end
			default: state_d = WS_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		q_pop      = 1'b0;
		mem_we     = 1'b0;
		start_data = 1'b0;
		step       = 1'b0;
		finish     = 1'b0;
		rd_addr    = cur_node_q;
		sym        = '0;
		case (state_q)
			WS_IDLE: begin
				q_pop      = q_valid;
				mem_we     = q_valid && q_item.is_load && ({1'b0, q_item.idx} < NODE_LIMIT);
				start_data = q_valid && !q_item.is_load;
			end
			WS_PREP: begin
				rd_addr = cur_node_q;
			end
			WS_BITS: begin
				step       = !produce || pend_ready;
				finish     = stop || (bit_idx_q == LAST_BIT);
				rd_addr    = step ? nxt_node : cur_node_q;
				sym.push   = produce && step;
				sym.finish = finish && step;
				sym.sym    = child_val;
				sym.done   = (count_inc == len_q);
			end
			default: begin
				rd_addr = cur_node_q;
			end
		endcase
	end

	// node store: one write for loads, one registered read for the walk
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[q_item.idx[ADDR_W-1:0]] <= q_item.node;
		end
		rd_node_q <= mem[rd_addr[ADDR_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= WS_IDLE;
			cur_node_q <= ROOT_NODE;
			count_q    <= '0;
			len_q      <= '0;
			bit_idx_q  <= '0;
			data_q     <= '0;
			rd_hit_q   <= 1'b0;
			rd_ok_q    <= 1'b0;
		end else begin
			state_q  <= state_d;
			rd_hit_q <= ({1'b0, rd_addr} < NODE_LIMIT);
			if (cfg_wr_en) begin
				len_q <= LENGTH_BITS'(cfg_wr_data);
			end
			// a load may change the node behind the prefetched read data
			if (mem_we || (state_q == WS_IDLE && q_valid && q_item.is_load)) begin
				rd_ok_q <= 1'b0;
			end else if (state_q == WS_PREP) begin
				rd_ok_q <= 1'b1;
			end
			if (start_data) begin
				data_q    <= q_item.data;
				bit_idx_q <= '0;
				if (q_item.first) begin
					cur_node_q <= ROOT_NODE;
					count_q    <= '0;
				end
			end
			if (step) begin
				bit_idx_q  <= bit_idx_q + 1'b1;
				cur_node_q <= nxt_node;
				if (produce) begin
					count_q <= count_inc;
				end
			end
		end
	end

endmodule

[design/htd_out.sv]
// ----------------------------------------------------------------------------
// htd_out
// Output side: holds the newest symbol until it is known whether it ends its
// input byte, then passes it to the master-side output register.
// ----------------------------------------------------------------------------
module htd_out import htd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sym_t                 sym,
	output logic                 pend_ready,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,
	output logic                 m_tlast,
	output logic [0:0]           m_tuser
);

	logic       pend_valid_q;
	logic       pend_last_q;
	logic [7:0] pend_sym_q;
	logic       pend_done_q;
	logic       out_valid_q;
	logic       out_last_q;
	logic [7:0] out_sym_q;
	logic       out_done_q;
	logic       can_move;
	logic       move;

	assign can_move   = !out_valid_q || m_tready;
	assign pend_ready = !pend_valid_q || can_move;
	// pending symbol leaves once a later one arrives or its byte has ended
	assign move       = pend_valid_q && (pend_last_q || sym.push) && can_move;

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = out_sym_q;
	assign m_tlast    = out_last_q;
	assign m_tuser    = out_done_q;

	always_ff @(posedge clk) begin
		if (sym.push) begin
			pend_sym_q  <= sym.sym;
			pend_done_q <= sym.done;
		end
		if (move) begin
			out_sym_q  <= pend_sym_q;
			out_done_q <= pend_done_q;
			out_last_q <= pend_last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			pend_last_q  <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (sym.push) begin
				pend_valid_q <= 1'b1;
				pend_last_q  <= sym.finish;
			end else if (move) begin
				pend_valid_q <= 1'b0;
				pend_last_q  <= 1'b0;
			end else if (sym.finish && pend_valid_q) begin
				pend_last_q <= 1'b1;
			end
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[design/huffman_tree_decoder_unit.sv]
// ----------------------------------------------------------------------------
// huffman_tree_decoder_unit
// Huffman tree walker: load items fill the node store, data bytes are
// decoded least significant bit first into symbol bytes.
// ----------------------------------------------------------------------------
// A data byte is first taken from the queue, then walked one bit per cycle
// while the output side takes its symbols, a rate set by the single read
// port of the node store feeding the next node address. A byte with
// first_byte set, the first byte after reset or the first byte after a load
// item first passes the prepare state, where the current node is fetched. A
// byte that meets a completed chunk ends at that point. A two-entry input
// queue and an output register let input and output stall independently;
// symbols of a byte appear at most one per cycle, the last one once its
// byte is finished.
module huffman_tree_decoder_unit import htd_pkg::*; #(
	parameter int NODE_COUNT  = 256,
	parameter int LENGTH_BITS = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// out_length
	input  logic                 cfg_wr_en,
	input  logic [CFG_W-1:0]     cfg_wr_data,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// first_byte, data_byte, node_index, left_value, left_is_node,
	// right_value, right_is_node, zero padding
	input  logic [S_TDATA_W-1:0] s_tdata,
	// cmd
	input  logic [0:0]           s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// out_byte
	output logic [M_TDATA_W-1:0] m_tdata,
	// run_last
	output logic                 m_tlast,
	// chunk_done
	output logic [0:0]           m_tuser
);

	logic  q_valid;
	item_t q_item;
	logic  q_pop;
	logic  pend_ready;
	sym_t  sym;

	htd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	htd_walk #(
		.NODE_COUNT  (NODE_COUNT),
		.LENGTH_BITS (LENGTH_BITS)
	) u_walk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.q_pop       (q_pop),
		.pend_ready  (pend_ready),
		.sym         (sym)
	);

	htd_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.sym        (sym),
		.pend_ready (pend_ready),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.m_tuser    (m_tuser)
	);

endmodule
